@@ rtl/pbrs_pkg.sv @@
// Package for the Poisson blend right-hand side stencil: payload types, register codes, helpers.
package pbrs_pkg;

	// Sizes fixed by the payload fields
	localparam int unsigned PIX_W       = 8;
	localparam int unsigned RHS_W       = 12;
	localparam int unsigned TERM_W      = 10;
	localparam int unsigned IDX_W       = 22;
	localparam int unsigned CFG_W       = 12;
	localparam int unsigned CFG_IDX_W   = 2;
	localparam int unsigned ROW_W       = 11;
	localparam int unsigned MAX_HEIGHT  = 2048;
	localparam int unsigned MAX_WIDTH_D = 2048;
	localparam int unsigned OUT_DEPTH   = 4;

	// Reset values of the configuration registers
	localparam logic [CFG_W-1:0] WIDTH_RST  = 12'd640;
	localparam logic [CFG_W-1:0] HEIGHT_RST = 12'd480;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIXED_GRADIENTS = 2'd2;

	// Channel codes
	localparam int unsigned CH_RED   = 0;
	localparam int unsigned CH_GREEN = 1;
	localparam int unsigned CH_BLUE  = 2;
	localparam int unsigned NUM_CH   = 3;
	localparam int unsigned NUM_NB   = 4;

	typedef struct packed {
		logic             mask_in;
		logic [PIX_W-1:0] src_red;
		logic [PIX_W-1:0] src_green;
		logic [PIX_W-1:0] src_blue;
		logic [PIX_W-1:0] dst_red;
		logic [PIX_W-1:0] dst_green;
		logic [PIX_W-1:0] dst_blue;
	} pix_in_t;

	typedef struct packed {
		logic signed [RHS_W-1:0] rhs_red;
		logic signed [RHS_W-1:0] rhs_green;
		logic signed [RHS_W-1:0] rhs_blue;
		logic [IDX_W-1:0]        unknown_index;
		logic                    frame_last;
	} rhs_out_t;

	// One line store entry: the row before last and the previous row at one column
	typedef struct packed {
		pix_in_t top;
		pix_in_t mid;
	} line_pair_t;

	function automatic logic [PIX_W-1:0] src_chan(pix_in_t p, int unsigned ch);
		logic [PIX_W-1:0] v;
		case (ch)
			CH_RED:   v = p.src_red;
			CH_GREEN: v = p.src_green;
			default:  v = p.src_blue;
		endcase
		return v;
	endfunction

	function automatic logic [PIX_W-1:0] dst_chan(pix_in_t p, int unsigned ch);
		logic [PIX_W-1:0] v;
		case (ch)
			CH_RED:   v = p.dst_red;
			CH_GREEN: v = p.dst_green;
			default:  v = p.dst_blue;
		endcase
		return v;
	endfunction

	// Contribution of one neighbour: boundary value plus guidance difference
	function automatic logic signed [TERM_W-1:0] nb_term(
		logic [PIX_W-1:0] sc, logic [PIX_W-1:0] dc,
		logic [PIX_W-1:0] sn, logic [PIX_W-1:0] dn,
		logic nb_mask, logic mixed);
		logic signed [PIX_W:0]   gs;
		logic signed [PIX_W:0]   gd;
		logic [PIX_W:0]          as;
		logic [PIX_W:0]          ad;
		logic signed [PIX_W:0]   g;
		logic signed [TERM_W-1:0] bnd;
		gs  = $signed({1'b0, sc}) - $signed({1'b0, sn});
		gd  = $signed({1'b0, dc}) - $signed({1'b0, dn});
		as  = gs[PIX_W] ? (PIX_W+1)'(-gs) : gs;
		ad  = gd[PIX_W] ? (PIX_W+1)'(-gd) : gd;
		g   = (mixed && !(as > ad)) ? gd : (mixed ? gs : gs);
		bnd = nb_mask ? '0 : $signed({{(TERM_W-PIX_W){1'b0}}, dn});
		return bnd + TERM_W'(g);
	endfunction

endpackage

@@ rtl/poisson_blend_rhs_stencil.sv @@
// Top level of the Poisson blend right-hand side stencil with its line store.

// Takes one pixel per clock in raster order while pix_stall is low and gives one result
// for every masked interior pixel, one row and one column behind the input. The line
// store is a single one-port-write, one-port-read memory of MAX_WIDTH entries, each
// holding the two previous rows at one column, so each pixel costs one read and one
// write and a new pixel follows every cycle while pix_stall is low. After reset the
// store is cleared at one entry per clock, during which pix_stall stays high;
// configuration writes are taken throughout. A four-deep output queue keeps the input
// flowing while the result side stalls, until queued and in-flight results fill it.
module poisson_blend_rhs_stencil #(
	parameter int unsigned MAX_WIDTH = pbrs_pkg::MAX_WIDTH_D
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 pix_valid,
	output logic                                 pix_stall,
	input  pbrs_pkg::pix_in_t                    pix,
	output logic                                 rhs_valid,
	input  logic                                 rhs_stall,
	output pbrs_pkg::rhs_out_t                   rhs,
	input  logic                                 cfg_wr_en,
	input  logic [pbrs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pbrs_pkg::CFG_W-1:0]           cfg_data
);
	import pbrs_pkg::*;

	localparam int unsigned CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int unsigned WCMP = (CW >= CFG_W) ? CW + 1 : CFG_W + 1;
	localparam int unsigned PW   = $clog2(OUT_DEPTH);
	localparam int unsigned QW   = $clog2(OUT_DEPTH + 1);

	// Configuration registers
	logic [CFG_W-1:0] width_q, height_q;
	logic             mixed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			mixed_q  <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:     width_q  <= cfg_data;
				REG_IMAGE_HEIGHT:    height_q <= cfg_data;
				REG_MIXED_GRADIENTS: mixed_q  <= cfg_data[0];
				default:             ;
			endcase
		end
	end

	// Saturated frame size
	logic [WCMP-1:0]  w_eff;
	logic [CFG_W-1:0] h_eff;

	always_comb begin
		if (WCMP'(width_q) < WCMP'(3))
			w_eff = WCMP'(3);
		else if (WCMP'(width_q) > WCMP'(MAX_WIDTH))
			w_eff = WCMP'(MAX_WIDTH);
		else
			w_eff = WCMP'(width_q);
		if (height_q < CFG_W'(3))
			h_eff = CFG_W'(3);
		else if (height_q > CFG_W'(MAX_HEIGHT))
			h_eff = CFG_W'(MAX_HEIGHT);
		else
			h_eff = height_q;
	end

	// Clearing pass over the line store after reset
	logic          clr_busy_q;
	logic [CW-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + CW'(1);
			if (clr_addr_q == CW'(MAX_WIDTH - 1))
				clr_busy_q <= 1'b0;
		end
	end

	// Output queue occupancy and input admission
	logic [QW-1:0] q_cnt_q;
	logic          v_s1, v_s2;
	logic [QW:0]   in_flight;
	logic          pix_acc;

	assign in_flight = (QW+1)'(q_cnt_q) + (QW+1)'(v_s1) + (QW+1)'(v_s2);
	assign pix_stall = clr_busy_q || (in_flight >= (QW+1)'(OUT_DEPTH));
	assign pix_acc   = pix_valid && !pix_stall;

	// Raster position of the next input pixel
	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic             row_end, frame_end;

	assign row_end   = WCMP'(col_q) >= (w_eff - WCMP'(1));
	assign frame_end = row_end && (CFG_W'(row_q) >= (h_eff - CFG_W'(1)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (pix_acc) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= frame_end ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Stage 1 pipeline registers: pixel and its position flags
	pix_in_t       cur_s1;
	logic [CW-1:0] col_s1;
	logic          inter_s1, frame_end_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else
			v_s1 <= pix_acc;
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			cur_s1       <= pix;
			col_s1       <= col_q;
			inter_s1     <= (row_q >= ROW_W'(2)) && (col_q >= CW'(2));
			frame_end_s1 <= frame_end;
		end
	end

	// Line store: read at acceptance, written back in the cycle after
	line_pair_t line_mem [MAX_WIDTH];
	line_pair_t mem_rd_s1;
	line_pair_t mem_wdata;
	logic [CW-1:0] mem_waddr;
	logic          mem_we;

	always_comb begin
		mem_we    = clr_busy_q || v_s1;
		mem_waddr = clr_busy_q ? clr_addr_q : col_s1;
		mem_wdata = clr_busy_q ? '0 : line_pair_t'{top: mem_rd_s1.mid, mid: cur_s1};
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			line_mem[mem_waddr] <= mem_wdata;
		if (pix_acc)
			mem_rd_s1 <= line_mem[col_q];
	end

	// Cross stencil window around the centre pixel
	pix_in_t w_up_q, w_ctr_q, w_left_q, w_down_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_up_q   <= '0;
			w_ctr_q  <= '0;
			w_left_q <= '0;
			w_down_q <= '0;
		end else if (v_s1) begin
			w_up_q   <= mem_rd_s1.top;
			w_left_q <= w_ctr_q;
			w_ctr_q  <= mem_rd_s1.mid;
			w_down_q <= cur_s1;
		end
	end

	// Unknown counter, advanced in stage 1 order
	logic             emit_s1;
	logic [IDX_W-1:0] unk_q;

	assign emit_s1 = v_s1 && inter_s1 && w_ctr_q.mask_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			unk_q <= '0;
		else if (v_s1 && frame_end_s1)
			unk_q <= '0;
		else if (emit_s1)
			unk_q <= unk_q + IDX_W'(1);
	end

	// Per-neighbour terms for each channel
	pix_in_t                  nb [NUM_NB];
	logic signed [TERM_W-1:0] term_c [NUM_CH][NUM_NB];

	always_comb begin
		nb[0] = w_up_q;
		nb[1] = w_down_q;
		nb[2] = w_left_q;
		nb[3] = mem_rd_s1.mid;
		for (int unsigned ch = 0; ch < NUM_CH; ch++) begin
			for (int unsigned k = 0; k < NUM_NB; k++) begin
				term_c[ch][k] = nb_term(src_chan(w_ctr_q, ch), dst_chan(w_ctr_q, ch),
					src_chan(nb[k], ch), dst_chan(nb[k], ch), nb[k].mask_in, mixed_q);
			end
		end
	end

	// Stage 2 registers
	logic signed [TERM_W-1:0] term_s2 [NUM_CH][NUM_NB];
	logic [IDX_W-1:0]         idx_s2;
	logic                     last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else
			v_s2 <= emit_s1;
	end

	always_ff @(posedge clk) begin
		if (emit_s1) begin
			term_s2 <= term_c;
			idx_s2  <= unk_q;
			last_s2 <= frame_end_s1;
		end
	end

	// Sum of the four terms per channel
	logic signed [RHS_W-1:0] sum_c [NUM_CH];
	rhs_out_t                push_data;

	always_comb begin
		for (int unsigned ch = 0; ch < NUM_CH; ch++) begin
			sum_c[ch] = '0;
			for (int unsigned k = 0; k < NUM_NB; k++)
				sum_c[ch] = sum_c[ch] + RHS_W'(term_s2[ch][k]);
		end
		push_data.rhs_red       = sum_c[CH_RED];
		push_data.rhs_green     = sum_c[CH_GREEN];
		push_data.rhs_blue      = sum_c[CH_BLUE];
		push_data.unknown_index = idx_s2;
		push_data.frame_last    = last_s2;
	end

	// Output queue
	rhs_out_t      q_mem [OUT_DEPTH];
	logic [PW-1:0] q_wr_q, q_rd_q;
	logic          q_push, q_pop;

	assign q_push    = v_s2;
	assign rhs_valid = (q_cnt_q != '0);
	assign q_pop     = rhs_valid && !rhs_stall;
	assign rhs       = q_mem[q_rd_q];

	always_ff @(posedge clk) begin
		if (q_push)
			q_mem[q_wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_wr_q  <= '0;
			q_rd_q  <= '0;
			q_cnt_q <= '0;
		end else begin
			if (q_push)
				q_wr_q <= (q_wr_q == PW'(OUT_DEPTH - 1)) ? '0 : q_wr_q + PW'(1);
			if (q_pop)
				q_rd_q <= (q_rd_q == PW'(OUT_DEPTH - 1)) ? '0 : q_rd_q + PW'(1);
			case ({q_push, q_pop})
				2'b10:   q_cnt_q <= q_cnt_q + QW'(1);
				2'b01:   q_cnt_q <= q_cnt_q - QW'(1);
				default: q_cnt_q <= q_cnt_q;
			endcase
		end
	end

	// Checks
	a_no_pix_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !pix_acc)
		else $error("pixel accepted during line store clearing");

	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (q_cnt_q < QW'(OUT_DEPTH)) || q_pop)
		else $error("output queue overflow");

	a_frame_end_clears_index: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && frame_end_s1) |=> (unk_q == '0))
		else $error("unknown index not cleared at end of frame");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(q_cnt_q == '0) |-> !q_pop)
		else $error("output queue read while empty");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the Poisson blend right-hand side stencil: driver, monitor, predictor.
module testbench;
	import pbrs_pkg::*;

	localparam int unsigned MAX_W          = MAX_WIDTH_D;
	localparam int unsigned TIMEOUT_CYCLES = 60000;
	localparam int unsigned DRAIN_CYCLES   = 12;
	localparam int unsigned RANDOM_PIXELS  = 900;
	localparam int unsigned WIDE_PIXELS    = 100;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic [CFG_W-1:0]     SIZE_OVER  = 12'hFFF;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 pix_valid = 1'b0;
	logic                 pix_stall;
	pix_in_t              pix       = '0;
	logic                 rhs_valid;
	logic                 rhs_stall = 1'b0;
	rhs_out_t             rhs;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;

	// Stimulus and scoreboard
	pix_in_t     pixels_to_send[$];
	rhs_out_t    rhs_awaited[$];
	rhs_out_t    want;
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned mismatches     = 0;
	int unsigned cycle_count    = 0;

	// Predictor state: two rows of history, the cross window, raster position, index count
	pix_in_t          row_prev[MAX_W];
	pix_in_t          row_before[MAX_W];
	pix_in_t          win_up, win_centre, win_left, win_down;
	int unsigned      col_pos, row_pos;
	logic [IDX_W-1:0] unknown_cnt;
	logic [CFG_W-1:0] width_reg, height_reg;
	logic             mixed_reg;

	poisson_blend_rhs_stencil #(
		.MAX_WIDTH(MAX_W)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pix(pix),
		.rhs_valid(rhs_valid),
		.rhs_stall(rhs_stall),
		.rhs(rhs),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Appends one pixel to the driver's pending list
	function automatic void queue_pixel(pix_in_t p);
		pixels_to_send = {pixels_to_send, p};
	endfunction

	// Colour level of one channel, source or destination side
	function automatic int level(pix_in_t p, int unsigned ch, bit dst);
		logic [PIX_W-1:0] v;
		case (ch)
			CH_RED:   v = dst ? p.dst_red : p.src_red;
			CH_GREEN: v = dst ? p.dst_green : p.src_green;
			default:  v = dst ? p.dst_blue : p.src_blue;
		endcase
		return int'(v);
	endfunction

	// One neighbour's share: boundary value if outside the mask, plus the guidance difference
	function automatic int guided_term(pix_in_t c, pix_in_t n, int unsigned ch);
		int gs, gd, mag_s, mag_d, t;
		gs    = level(c, ch, 1'b0) - level(n, ch, 1'b0);
		gd    = level(c, ch, 1'b1) - level(n, ch, 1'b1);
		mag_s = (gs < 0) ? -gs : gs;
		mag_d = (gd < 0) ? -gd : gd;
		t     = n.mask_in ? 0 : level(n, ch, 1'b1);
		// mixed mode keeps the source only when strictly steeper; ties go to destination
		if (mixed_reg && !(mag_s > mag_d))
			t += gd;
		else
			t += gs;
		return t;
	endfunction

	function automatic logic signed [RHS_W-1:0] channel_rhs(pix_in_t right, int unsigned ch);
		return RHS_W'(guided_term(win_centre, win_up, ch) + guided_term(win_centre, win_down, ch)
			+ guided_term(win_centre, win_left, ch) + guided_term(win_centre, right, ch));
	endfunction

	function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned hi);
		if (v < 3)
			return 3;
		if (v > hi)
			return hi;
		return 32'(v);
	endfunction

	// Steps the stencil by one accepted pixel and queues the result it gives, if any
	function automatic void advance_stencil(pix_in_t p);
		int unsigned w, h, ci;
		bit          row_end, frame_end;
		pix_in_t     top_c, mid_c;
		rhs_out_t    r;
		w         = clamp_dim(width_reg, MAX_W);
		h         = clamp_dim(height_reg, MAX_HEIGHT);
		ci        = col_pos % MAX_W;
		row_end   = (col_pos >= w - 1);
		frame_end = row_end && (row_pos >= h - 1);
		top_c     = row_before[ci];
		mid_c     = row_prev[ci];
		if (row_pos >= 2 && col_pos >= 2 && win_centre.mask_in) begin
			r.rhs_red       = channel_rhs(mid_c, CH_RED);
			r.rhs_green     = channel_rhs(mid_c, CH_GREEN);
			r.rhs_blue      = channel_rhs(mid_c, CH_BLUE);
			r.unknown_index = unknown_cnt;
			r.frame_last    = frame_end;
			rhs_awaited     = {rhs_awaited, r};
			unknown_cnt = unknown_cnt + 1'b1;
		end
		win_up          = top_c;
		win_left        = win_centre;
		win_centre      = mid_c;
		win_down        = p;
		row_before[ci]  = mid_c;
		row_prev[ci]    = p;
		if (row_end) begin
			col_pos = 0;
			if (frame_end) begin
				row_pos     = 0;
				unknown_cnt = '0;
			end else begin
				row_pos = row_pos + 1;
			end
		end else begin
			col_pos = col_pos + 1;
		end
	endfunction

	// Random level; the narrow palette makes equal gradients and extremes common
	function automatic logic [PIX_W-1:0] rand_level(bit narrow);
		logic [PIX_W-1:0] v;
		v = PIX_W'($urandom_range(255));
		if (narrow && $urandom_range(1) == 1) begin
			case ($urandom_range(3))
				0:       v = 8'd0;
				1:       v = 8'd255;
				2:       v = 8'd128;
				default: v = 8'd127;
			endcase
		end
		return v;
	endfunction

	function automatic pix_in_t rand_pix(int unsigned mask_pct, bit narrow);
		pix_in_t p;
		p.mask_in   = ($urandom_range(99) < mask_pct);
		p.src_red   = rand_level(narrow);
		p.src_green = rand_level(narrow);
		p.src_blue  = rand_level(narrow);
		p.dst_red   = rand_level(narrow);
		p.dst_green = rand_level(narrow);
		p.dst_blue  = rand_level(narrow);
		return p;
	endfunction

	// Grey pixel: the same level on every channel
	function automatic pix_in_t flat_pix(logic m, logic [PIX_W-1:0] s, logic [PIX_W-1:0] d);
		pix_in_t p;
		p.mask_in   = m;
		p.src_red   = s;
		p.src_green = s;
		p.src_blue  = s;
		p.dst_red   = d;
		p.dst_green = d;
		p.dst_blue  = d;
		return p;
	endfunction

	// Register write, only ever issued while no pixel or result is in flight
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_IMAGE_WIDTH:     width_reg  = value;
			REG_IMAGE_HEIGHT:    height_reg = value;
			REG_MIXED_GRADIENTS: mixed_reg  = value[0];
			default: ;
		endcase
	endtask

	// Wait until every pixel is taken and every result is back, then let the pipeline empty
	task automatic settle();
		@(negedge clk);
		while (pixels_to_send.size() != 0 || pix_valid || rhs_awaited.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic run_phase(int unsigned n, int unsigned mask_pct, bit narrow,
		int unsigned idle_pct, int unsigned stall_pct);
		@(negedge clk);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (n) queue_pixel(rand_pix(mask_pct, narrow));
		settle();
	endtask

	// Pixel driver
	always @(posedge clk) begin
		if (!arst_n) begin
			pix_valid <= 1'b0;
		end else if (!pix_valid || !pix_stall) begin
			if (pixels_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				pix       <= pixels_to_send.pop_front();
				pix_valid <= 1'b1;
			end else begin
				pix_valid <= 1'b0;
			end
		end
	end

	// Result monitor: stall pattern, comparison, and prediction of each accepted pixel
	always @(posedge clk) begin
		if (!arst_n) begin
			rhs_stall <= 1'b0;
		end else begin
			rhs_stall <= ($urandom_range(99) < recv_stall_pct);
			if (rhs_valid && !rhs_stall) begin
				if (rhs_awaited.size() == 0) begin
					$error("unexpected result, unknown_index %0d", rhs.unknown_index);
					mismatches++;
				end else begin
					want = rhs_awaited.pop_front();
					if (rhs.rhs_red !== want.rhs_red) begin
						$error("rhs_red: expected %0d, got %0d", want.rhs_red, rhs.rhs_red);
						mismatches++;
					end
					if (rhs.rhs_green !== want.rhs_green) begin
						$error("rhs_green: expected %0d, got %0d", want.rhs_green, rhs.rhs_green);
						mismatches++;
					end
					if (rhs.rhs_blue !== want.rhs_blue) begin
						$error("rhs_blue: expected %0d, got %0d", want.rhs_blue, rhs.rhs_blue);
						mismatches++;
					end
					if (rhs.unknown_index !== want.unknown_index) begin
						$error("unknown_index: expected %0d, got %0d",
							want.unknown_index, rhs.unknown_index);
						mismatches++;
					end
					if (rhs.frame_last !== want.frame_last) begin
						$error("frame_last: expected %0d, got %0d", want.frame_last, rhs.frame_last);
						mismatches++;
					end
				end
			end
			if (pix_valid && !pix_stall)
				advance_stencil(pix);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == TIMEOUT_CYCLES) begin
			$display("testbench: errors");
			$finish;
		end
	end

	initial begin
		int unsigned      sent;
		int unsigned      phase;
		int unsigned      n;
		int unsigned      mask_pct;
		logic [CFG_W-1:0] w, h;
		foreach (row_prev[i]) begin
			row_prev[i]   = '0;
			row_before[i] = '0;
		end
		win_up      = '0;
		win_centre  = '0;
		win_left    = '0;
		win_down    = '0;
		col_pos     = 0;
		row_pos     = 0;
		unknown_cnt = '0;
		width_reg   = WIDTH_RST;
		height_reg  = HEIGHT_RST;
		mixed_reg   = 1'b0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Sizes below range fall back to 3x3; only bit 0 of the mode register counts
		write_reg(REG_IMAGE_WIDTH, 12'd1);
		write_reg(REG_IMAGE_HEIGHT, 12'd0);
		write_reg(REG_MIXED_GRADIENTS, 12'hFFE);
		@(negedge clk);
		// Largest value: all four neighbours on the boundary, steepest source gradients
		for (int i = 0; i < 9; i++) begin
			case (i)
				4:          queue_pixel(flat_pix(1'b1, 8'd255, 8'd0));
				1, 3, 5, 7: queue_pixel(flat_pix(1'b0, 8'd0, 8'd255));
				default:    queue_pixel(rand_pix(50, 1'b0));
			endcase
		end
		// Smallest value: all neighbours inside the mask and brighter than the centre
		for (int i = 0; i < 9; i++) begin
			case (i)
				4:          queue_pixel(flat_pix(1'b1, 8'd0, 8'd17));
				1, 3, 5, 7: queue_pixel(flat_pix(1'b1, 8'd255, 8'($urandom_range(255))));
				default:    queue_pixel(rand_pix(50, 1'b0));
			endcase
		end
		settle();

		// Mixed mode on a 3x4 frame: source wins, tie, destination wins, flat;
		// the last interior pixel is outside the mask so the frame has no end mark
		write_reg(REG_IMAGE_WIDTH, 12'd3);
		write_reg(REG_IMAGE_HEIGHT, 12'd4);
		write_reg(REG_MIXED_GRADIENTS, 12'd1);
		@(negedge clk);
		for (int i = 0; i < 12; i++) begin
			case (i)
				1:       queue_pixel(flat_pix(1'b1, 8'd0, 8'd90));
				3:       queue_pixel(flat_pix(1'b0, 8'd95, 8'd200));
				4:       queue_pixel(flat_pix(1'b1, 8'd100, 8'd100));
				5:       queue_pixel(flat_pix(1'b0, 8'd100, 8'd100));
				7:       queue_pixel(flat_pix(1'b0, 8'd110, 8'd110));
				default: queue_pixel(rand_pix(50, 1'b1));
			endcase
		end
		settle();

		// Start of a row at the widest setting, the width written above range
		write_reg(REG_IMAGE_WIDTH, SIZE_OVER);
		write_reg(REG_IMAGE_HEIGHT, 12'd3);
		run_phase(WIDE_PIXELS, 90, 1'b1, 0, 0);

		// Random phases; sizes change between phases, often in the middle of a frame
		sent  = 0;
		phase = 0;
		while (sent < RANDOM_PIXELS) begin
			case ($urandom_range(9))
				0:       w = CFG_W'($urandom_range(2));
				1:       w = CFG_W'(MAX_W);
				default: w = CFG_W'($urandom_range(3, 9));
			endcase
			case ($urandom_range(9))
				0:       h = CFG_W'($urandom_range(2));
				1:       h = SIZE_OVER;
				default: h = CFG_W'($urandom_range(3, 7));
			endcase
			write_reg(REG_IMAGE_WIDTH, w);
			write_reg(REG_IMAGE_HEIGHT, h);
			write_reg(REG_MIXED_GRADIENTS, CFG_W'($urandom_range(4095)));
			if ($urandom_range(3) == 0)
				write_reg(REG_UNUSED, CFG_W'($urandom_range(4095)));
			case ($urandom_range(2))
				0:       mask_pct = 30;
				1:       mask_pct = 70;
				default: mask_pct = 95;
			endcase
			n = $urandom_range(40, 120);
			case (phase % 4)
				0:       run_phase(n, mask_pct, 1'($urandom_range(1)), 0, 0);
				1:       run_phase(n, mask_pct, 1'($urandom_range(1)), 79, 0);
				2:       run_phase(n, mask_pct, 1'($urandom_range(1)), 0, 79);
				default: run_phase(n, mask_pct, 1'($urandom_range(1)), 24, 24);
			endcase
			sent  += n;
			phase += 1;
		end

		if (mismatches == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
